[hdl/eab_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eab_pkg
// types and constants shared by the euler angles to basis vectors block
// ----------------------------------------------------------------------------
package eab_pkg;

	localparam int unsigned Q = 30;
	localparam logic [63:0] PIH_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE = 64'd1 << Q;

	// reciprocal constants for the horner divisors, exact for 32-bit dividends
	localparam int unsigned HS_156 = 40;
	localparam int unsigned HS_110 = 39;
	localparam int unsigned HS_72  = 39;
	localparam int unsigned HS_42  = 38;
	localparam int unsigned HS_20  = 37;
	localparam int unsigned HS_6   = 35;
	localparam logic [32:0] HM_156 = 33'(((66'd1 << HS_156) / 66'd156) + 66'd1);
	localparam logic [32:0] HM_110 = 33'(((66'd1 << HS_110) / 66'd110) + 66'd1);
	localparam logic [32:0] HM_72  = 33'(((66'd1 << HS_72) / 66'd72) + 66'd1);
	localparam logic [32:0] HM_42  = 33'(((66'd1 << HS_42) / 66'd42) + 66'd1);
	localparam logic [32:0] HM_20  = 33'(((66'd1 << HS_20) / 66'd20) + 66'd1);
	localparam logic [32:0] HM_6   = 33'(((66'd1 << HS_6) / 66'd6) + 66'd1);

	typedef logic signed [31:0] q30_t;
	typedef logic signed [15:0] comp_t;

	typedef struct packed {
		logic [15:0] pitch_angle;
		logic [15:0] yaw_angle;
		logic [15:0] roll_angle;
	} in_word_t;

	typedef struct packed {
		comp_t fwd_x;
		comp_t fwd_y;
		comp_t fwd_z;
		comp_t right_x;
		comp_t right_y;
		comp_t right_z;
		comp_t up_x;
		comp_t up_y;
		comp_t up_z;
	} out_word_t;

	// horner reciprocal multiplier for step i
	function automatic logic [32:0] horner_m(input int unsigned i);
		logic [32:0] m;
		begin
			unique case (i)
				0: m = HM_156;
				1: m = HM_110;
				2: m = HM_72;
				3: m = HM_42;
				4: m = HM_20;
				default: m = HM_6;
			endcase
			return m;
		end
	endfunction

	// horner reciprocal shift for step i
	function automatic int unsigned horner_sh(input int unsigned i);
		int unsigned s;
		begin
			unique case (i)
				0: s = HS_156;
				1: s = HS_110;
				2: s = HS_72;
				3: s = HS_42;
				4: s = HS_20;
				default: s = HS_6;
			endcase
			return s;
		end
	endfunction

	// signed q30 product, ties away from zero
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic        neg;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [63:0] p;
		begin
			neg = a[31] ^ b[31];
			ma  = a[31] ? 32'(-a) : 32'(a);
			mb  = b[31] ? 32'(-b) : 32'(b);
			p   = ({32'd0, ma} * {32'd0, mb} + (64'd1 << 29)) >> 30;
			return neg ? q30_t'(-p[31:0]) : q30_t'(p[31:0]);
		end
	endfunction

endpackage
`default_nettype wire

[hdl/eab_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eab_in_if / eab_out_if
// valid-ready channels for orientation and basis words
// ----------------------------------------------------------------------------
interface eab_in_if;
	logic              valid;
	logic              ready;
	eab_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface eab_out_if;
	logic               valid;
	logic               ready;
	eab_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/eab_sincos_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eab_sincos_lane
// pipelined sine and cosine of one binary angle, q30 results
// ----------------------------------------------------------------------------
module eab_sincos_lane #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [15:0]                   angle,
	output eab_pkg::q30_t                      sin_o,
	output eab_pkg::q30_t                      cos_o
);
	localparam int RB = ANGLE_BITS - 2;
	localparam int NS = 6;

	// two sine paths: index 0 sine, index 1 cosine
	logic [RB:0]   r_c    [2];
	logic [1:0]    neg_c;
	logic [30:0]   x_s1   [2];
	logic [1:0]    neg_s1;
	logic [30:0]   t_p    [2][NS+1];
	logic [30:0]   x_p    [2][NS+1];
	logic [31:0]   x2_p   [2][NS+1];
	logic [1:0]    neg_p  [NS+1];
	logic [31:0]   n_p    [2][NS];
	logic [30:0]   xn_p   [2][NS];
	logic [31:0]   x2n_p  [2][NS];
	logic [1:0]    negn_p [NS];
	eab_pkg::q30_t res_c  [2];

	// floor division by the horner divisor of step i
	function automatic logic [31:0] div_step(input logic [31:0] n, input int unsigned i);
		logic [65:0] p;
		begin
			p = 66'(n) * 66'(eab_pkg::horner_m(i));
			return 32'(p >> eab_pkg::horner_sh(i));
		end
	endfunction

	always_comb begin
		logic [ANGLE_BITS-1:0] a;
		logic [ANGLE_BITS-1:0] c;
		a = angle[ANGLE_BITS-1:0];
		c = a + ANGLE_BITS'(1 << RB);
		neg_c[0] = a[ANGLE_BITS-1];
		neg_c[1] = c[ANGLE_BITS-1];
		r_c[0] = a[ANGLE_BITS-2] ? ((RB+1)'(1) << RB) - {1'b0, a[RB-1:0]}
		                         : {1'b0, a[RB-1:0]};
		r_c[1] = c[ANGLE_BITS-2] ? ((RB+1)'(1) << RB) - {1'b0, c[RB-1:0]}
		                         : {1'b0, c[RB-1:0]};
	end

	// each horner step takes two stages: product, then reciprocal divide
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				x_s1[k]    <= 31'((64'(r_c[k]) * eab_pkg::PIH_Q30) >> RB);
				t_p[k][0]  <= 31'(eab_pkg::Q30_ONE);
				x_p[k][0]  <= x_s1[k];
				x2_p[k][0] <= 32'((64'(x_s1[k]) * 64'(x_s1[k])) >> 30);
				for (int i = 0; i < NS; i++) begin
					n_p[k][i]    <= 32'((64'(x2_p[k][i]) * 64'(t_p[k][i])) >> 30);
					xn_p[k][i]   <= x_p[k][i];
					x2n_p[k][i]  <= x2_p[k][i];
					t_p[k][i+1]  <= 31'(eab_pkg::Q30_ONE - 64'(div_step(n_p[k][i], i)));
					x_p[k][i+1]  <= xn_p[k][i];
					x2_p[k][i+1] <= x2n_p[k][i];
				end
			end
			neg_s1   <= neg_c;
			neg_p[0] <= neg_s1;
			for (int i = 0; i < NS; i++) begin
				negn_p[i]  <= neg_p[i];
				neg_p[i+1] <= negn_p[i];
			end
		end
	end

	always_comb begin
		logic [63:0] s;
		for (int k = 0; k < 2; k++) begin
			s = (64'(x_p[k][NS]) * 64'(t_p[k][NS])) >> 30;
			if (s > eab_pkg::Q30_ONE) s = eab_pkg::Q30_ONE;
			res_c[k] = neg_p[NS][k] ? eab_pkg::q30_t'(-s[31:0])
			                        : eab_pkg::q30_t'(s[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= res_c[0];
			cos_o <= res_c[1];
		end
	end
endmodule
`default_nettype wire

[hdl/eab_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eab_merge
// combines the three lanes' sines and cosines into the nine components
// ----------------------------------------------------------------------------
module eab_merge #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  eab_pkg::q30_t      sp,
	input  eab_pkg::q30_t      cp,
	input  eab_pkg::q30_t      sy,
	input  eab_pkg::q30_t      cy,
	input  eab_pkg::q30_t      sr,
	input  eab_pkg::q30_t      cr,
	output eab_pkg::out_word_t res
);
	localparam int SH = 30 - FRAC_BITS;

	eab_pkg::q30_t nsr_sp_s1, cr_sp_s1, sp_s1, cp_s1, sy_s1, cy_s1, sr_s1, cr_s1;
	eab_pkg::q30_t v_s2 [9];

	function automatic eab_pkg::comp_t to_out(input logic signed [33:0] v);
		logic        neg;
		logic [33:0] m;
		begin
			neg = v[33];
			m   = neg ? 34'(-v) : 34'(v);
			if (SH > 0) m = (m + (34'd1 << (SH > 0 ? SH - 1 : 0))) >> SH;
			if (m > (34'd1 << FRAC_BITS)) m = 34'd1 << FRAC_BITS;
			return neg ? eab_pkg::comp_t'(-m[15:0]) : eab_pkg::comp_t'(m[15:0]);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			nsr_sp_s1 <= eab_pkg::mul_q30(-sr, sp);
			cr_sp_s1  <= eab_pkg::mul_q30(cr, sp);
			sp_s1 <= sp; cp_s1 <= cp; sy_s1 <= sy;
			cy_s1 <= cy; sr_s1 <= sr; cr_s1 <= cr;
		end
	end

	logic signed [33:0] r3, r4, r6, r7;
	always_comb begin
		r3 = 34'(eab_pkg::mul_q30(nsr_sp_s1, cy_s1)) + 34'(eab_pkg::mul_q30(cr_s1, sy_s1));
		r4 = 34'(eab_pkg::mul_q30(nsr_sp_s1, sy_s1)) - 34'(eab_pkg::mul_q30(cr_s1, cy_s1));
		r6 = 34'(eab_pkg::mul_q30(cr_sp_s1, cy_s1)) + 34'(eab_pkg::mul_q30(sr_s1, sy_s1));
		r7 = 34'(eab_pkg::mul_q30(cr_sp_s1, sy_s1)) - 34'(eab_pkg::mul_q30(sr_s1, cy_s1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.fwd_x   <= to_out(34'(eab_pkg::mul_q30(cp_s1, cy_s1)));
			res.fwd_y   <= to_out(34'(eab_pkg::mul_q30(cp_s1, sy_s1)));
			res.fwd_z   <= to_out(-34'(sp_s1));
			res.right_x <= to_out(r3);
			res.right_y <= to_out(r4);
			res.right_z <= to_out(34'(eab_pkg::mul_q30(-sr_s1, cp_s1)));
			res.up_x    <= to_out(r6);
			res.up_y    <= to_out(r7);
			res.up_z    <= to_out(34'(eab_pkg::mul_q30(cr_s1, cp_s1)));
		end
	end
endmodule
`default_nettype wire

[hdl/euler_angles_to_basis_vectors_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors_unit
// throughput one word per cycle; pipeline stalls as a whole on output backpressure
// three sine/cosine lanes (15 stages) feed a 2-stage merge
// reset clears the valid pipeline only, payload is unreset
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors_unit #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	eab_in_if.sink   in_ch,
	eab_out_if.source out_ch
);
	localparam int LAT = 17;

	logic [LAT-1:0] vld_q;
	logic           en;
	eab_pkg::q30_t  s [3];
	eab_pkg::q30_t  c [3];

	assign en = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	eab_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk(clk), .en(en), .angle(in_ch.data.pitch_angle), .sin_o(s[0]), .cos_o(c[0]));
	eab_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk(clk), .en(en), .angle(in_ch.data.yaw_angle), .sin_o(s[1]), .cos_o(c[1]));
	eab_sincos_lane #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk(clk), .en(en), .angle(in_ch.data.roll_angle), .sin_o(s[2]), .cos_o(c[2]));

	eab_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk(clk), .en(en),
		.sp(s[0]), .cp(c[0]), .sy(s[1]), .cy(c[1]), .sr(s[2]), .cr(c[2]),
		.res(out_ch.data));

	assign out_ch.valid = vld_q[LAT-1];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result lost under backpressure");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
	a_fwdz_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ($signed(out_ch.data.fwd_z) <= 16'sd16384 &&
		                  $signed(out_ch.data.fwd_z) >= -16'sd16384))
		else $error("component out of range");
endmodule
`default_nettype wire

[tb/tb_euler_angles_to_basis_vectors_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_angles_to_basis_vectors_unit
// streams orientation words through the block and compares every basis word
// with an in-bench fixed-point model, under varied idle and stall patterns
// ----------------------------------------------------------------------------
module tb_euler_angles_to_basis_vectors_unit;

	localparam int ABITS = 16;
	localparam int FBITS = 14;
	localparam longint unsigned ONE30 = 64'd1 << 30;
	localparam longint unsigned PIH = 64'd1686629713;
	localparam longint unsigned QTR = 64'd1 << (ABITS - 2);
	localparam int LIMIT = 2000000;

	logic clk;
	logic arst_n;

	eab_in_if  in_ch ();
	eab_out_if out_ch ();

	euler_angles_to_basis_vectors_unit #(.ANGLE_BITS(ABITS), .FRAC_BITS(FBITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	eab_pkg::in_word_t  pending_q[$];
	eab_pkg::out_word_t basis_q[$];
	int        src_idle_pct;
	int        snk_stall_pct;
	int        hold_off = 0;
	bit        hold_go = 1'b0;
	bit        hold_done = 1'b0;
	bit        pause_src;
	int        mismatches = 0;
	int        cycles = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint unsigned quarter_sine(longint unsigned r);
		longint unsigned x, x2, t, s;
		longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
		x  = (r * PIH) >> (ABITS - 2);
		x2 = (x * x) >> 30;
		t  = ONE30;
		for (int i = 0; i < 6; i++)
			t = ONE30 - (((x2 * t) >> 30) / divs[i]);
		s = (x * t) >> 30;
		if (s > ONE30)
			s = ONE30;
		return s;
	endfunction

	function automatic longint angle_sine(longint unsigned a);
		longint unsigned quad, r, m;
		a    = a & ((64'd1 << ABITS) - 1);
		quad = (a >> (ABITS - 2)) & 3;
		r    = a & (QTR - 1);
		m    = quad[0] ? quarter_sine(QTR - r) : quarter_sine(r);
		return quad[1] ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint angle_cosine(longint unsigned a);
		return angle_sine(a + QTR);
	endfunction

	function automatic longint qmul(longint a, longint b);
		bit neg;
		longint unsigned ma, mb, p;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		p   = (ma * mb + (64'd1 << 29)) >> 30;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function automatic eab_pkg::comp_t to_comp(longint v);
		bit neg;
		longint unsigned m;
		longint r;
		neg = v < 0;
		m   = neg ? -v : v;
		if (30 - FBITS > 0)
			m = (m + (64'd1 << (30 - FBITS - 1))) >> (30 - FBITS);
		if (m > (64'd1 << FBITS))
			m = 64'd1 << FBITS;
		r = neg ? -longint'(m) : longint'(m);
		return eab_pkg::comp_t'(r);
	endfunction

	function automatic eab_pkg::out_word_t basis_of(eab_pkg::in_word_t w);
		longint sp, cp, sy, cy, sr, cr, nsr, nsr_sp, cr_sp;
		eab_pkg::out_word_t o;
		sp = angle_sine(w.pitch_angle);
		cp = angle_cosine(w.pitch_angle);
		sy = angle_sine(w.yaw_angle);
		cy = angle_cosine(w.yaw_angle);
		sr = angle_sine(w.roll_angle);
		cr = angle_cosine(w.roll_angle);
		nsr    = -sr;
		nsr_sp = qmul(nsr, sp);
		cr_sp  = qmul(cr, sp);
		o.fwd_x   = to_comp(qmul(cp, cy));
		o.fwd_y   = to_comp(qmul(cp, sy));
		o.fwd_z   = to_comp(-sp);
		o.right_x = to_comp(qmul(nsr_sp, cy) + qmul(cr, sy));
		o.right_y = to_comp(qmul(nsr_sp, sy) - qmul(cr, cy));
		o.right_z = to_comp(qmul(nsr, cp));
		o.up_x    = to_comp(qmul(cr_sp, cy) + qmul(sr, sy));
		o.up_y    = to_comp(qmul(cr_sp, sy) - qmul(sr, cy));
		o.up_z    = to_comp(qmul(cr, cp));
		return o;
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 3)) << 14;
			1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 8))
				- 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				basis_q.push_back(basis_of(in_ch.data));
				void'(pending_q.pop_front());
			end
			if (in_ch.valid && !in_ch.ready) begin
				in_ch.valid <= 1'b1;
			end else if (pending_q.size() > 0 && !pause_src
				&& $urandom_range(0, 99) >= src_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_q[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		eab_pkg::out_word_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (basis_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected basis word %h", out_ch.data);
				end else begin
					e = basis_q.pop_front();
					if (out_ch.data !== e) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h got %h", e, out_ch.data);
					end
				end
			end
			out_ch.ready <= (hold_off == 0) && ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_off  <= 300;
			hold_done <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_angles(logic [15:0] p, logic [15:0] y, logic [15:0] r);
		eab_pkg::in_word_t w;
		w.pitch_angle = p;
		w.yaw_angle   = y;
		w.roll_angle  = r;
		pending_q.push_back(w);
	endtask

	task automatic drain();
		while (pending_q.size() > 0 || in_ch.valid || basis_q.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] edges[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'hFFFF, 16'h3FFF, 16'h0001, 16'h2000};
		int pct_src[4] = '{0, 74, 0, 21};
		int pct_snk[4] = '{0, 0, 74, 21};
		pause_src     = 1'b0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 8; i++)
			queue_angles(edges[i], edges[7 - i], edges[(i + 3) % 8]);
		queue_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_angles(16'h5555, 16'hAAAA, 16'h0000);
		queue_angles(16'hAAAA, 16'h5555, 16'hFFFF);
		queue_angles(16'h1C72, 16'h638E, 16'hE38E);
		drain();

		// receiver holds off while the sender keeps offering
		hold_go = 1'b1;
		for (int i = 0; i < 60; i++)
			queue_angles(rand_angle(), rand_angle(), rand_angle());
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct  = pct_src[ph];
			snk_stall_pct = pct_snk[ph];
			for (int i = 0; i < 380; i++)
				queue_angles(rand_angle(), rand_angle(), rand_angle());
			// sender waits for every result mid-phase
			while (pending_q.size() > 190)
				@(posedge clk);
			pause_src = 1'b1;
			while (in_ch.valid || basis_q.size() > 0)
				@(posedge clk);
			pause_src = 1'b0;
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && basis_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
